[rtl/uvs_pkg.sv]
// uvs_pkg: types, widths and constants shared by the UV sphere vertex generator.
// Holds the arctangent table of the CORDIC cells and the item and result structs.
// No dependencies.
`default_nettype none

package uvs_pkg;

   // restoring divider: 41-bit dividend word, remainder below twice the level
   localparam int DIV_W = 41;
   localparam int REM_W = 9;
   localparam int LVL_W = 8;
   localparam int IDX_W = 10;

   // CORDIC datapath widths and sine/cosine width (Q2.30)
   localparam int CX_W = 34;
   localparam int CZ_W = 32;
   localparam int CS_W = 32;
   localparam int NV_W = 33;
   localparam int AUX_W = 17;
   localparam int ATAN_N = 24;

   localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [31:0] ATAN_TURNS [0:ATAN_N-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   // register indexes of the configuration port
   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_LEVEL  = 2'd1;

   // operations issued per item, one per cycle
   localparam logic [1:0] OP_LAT_LO = 2'd0;
   localparam logic [1:0] OP_LAT_HI = 2'd1;
   localparam logic [1:0] OP_LON    = 2'd2;

   localparam logic [1:0] SLOT_LAST = 2'd3;

   typedef struct packed {
      logic [7:0] band_index;
      logic [8:0] meridian_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         vertex_slot;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
      logic               last;
      logic               bad_index;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             bad;
      logic [1:0]       op;
      logic [AUX_W-1:0] aux;
   } op_tag_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DIV_W-1:0] word;
   } div_lane_type;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [CZ_W-1:0] z;
      logic [1:0]             quad;
   } rot_type;

   typedef struct packed {
      logic                   valid;
      logic                   bad;
      logic                   last;
      logic [1:0]             slot;
      logic signed [CS_W-1:0] clat;
      logic signed [NV_W-1:0] slat;
      logic signed [CS_W-1:0] clon;
      logic signed [CS_W-1:0] slon;
      logic [AUX_W-1:0]       tex_u;
      logic [AUX_W-1:0]       tex_v;
   } vtx_op_type;

endpackage

`default_nettype wire

[rtl/uvs_div_cell.sv]
// uvs_div_cell: one step of a two-lane restoring divider, one quotient bit per lane.
// The word shifts left each step and takes the quotient bit in at the bottom.
// Depends on uvs_pkg.
`default_nettype none

module uvs_div_cell
   import uvs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [REM_W-1:0] divisor,
   input  wire op_tag_type       up_tag,
   input  wire div_lane_type     up_a,
   input  wire div_lane_type     up_b,
   output op_tag_type            dn_tag,
   output div_lane_type          dn_a,
   output div_lane_type          dn_b
);

   function automatic div_lane_type div_step(div_lane_type l, logic [REM_W-1:0] d);
      logic [REM_W:0] t;
      logic           q;
      div_lane_type   r;
      t = {l.rem, l.word[DIV_W-1]};
      q = (t >= {1'b0, d});
      r.rem = q ? REM_W'(t - {1'b0, d}) : t[REM_W-1:0];
      r.word = {l.word[DIV_W-2:0], q};
      return r;
   endfunction

   op_tag_type   tag_ff;
   div_lane_type lane_a_ff, lane_a_in;
   div_lane_type lane_b_ff, lane_b_in;

   // take one bit of the dividend on each lane
   always_comb begin
      lane_a_in = div_step(up_a, divisor);
      lane_b_in = div_step(up_b, divisor);
   end

   // hold the step result for the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff <= up_tag;
      end
      lane_a_ff <= lane_a_in;
      lane_b_ff <= lane_b_in;
   end

   assign dn_tag = tag_ff;
   assign dn_a   = lane_a_ff;
   assign dn_b   = lane_b_ff;

endmodule

`default_nettype wire

[rtl/uvs_cordic_cell.sv]
// uvs_cordic_cell: one rotation-mode CORDIC step with a fixed shift and arctangent.
// Angles are turns in Q0.32; x and y are Q4.30 with floor shifts.
// Depends on uvs_pkg.
`default_nettype none

module uvs_cordic_cell
   import uvs_pkg::*;
#(
   parameter int STEP = 0
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire op_tag_type up_tag,
   input  wire rot_type    up_rot,
   output op_tag_type      dn_tag,
   output rot_type         dn_rot
);

   localparam logic signed [CZ_W-1:0] ANGLE = signed'(ATAN_TURNS[STEP]);

   op_tag_type             tag_ff;
   rot_type                rot_ff, rot_in;
   logic signed [CX_W-1:0] x_cur, y_cur, dx, dy;

   // rotate towards zero residual angle
   always_comb begin
      x_cur = up_rot.x;
      y_cur = up_rot.y;
      dx = y_cur >>> STEP;
      dy = x_cur >>> STEP;
      rot_in.quad = up_rot.quad;
      if (!up_rot.z[CZ_W-1]) begin
         rot_in.x = x_cur - dx;
         rot_in.y = y_cur + dy;
         rot_in.z = up_rot.z - ANGLE;
      end else begin
         rot_in.x = x_cur + dx;
         rot_in.y = y_cur - dy;
         rot_in.z = up_rot.z + ANGLE;
      end
   end

   // hold the step result for the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff <= up_tag;
      end
      rot_ff <= rot_in;
   end

   assign dn_tag = tag_ff;
   assign dn_rot = rot_ff;

endmodule

`default_nettype wire

[rtl/uvs_vertex_unit.sv]
// uvs_vertex_unit: three-stage pipeline from sines and cosines to one vertex item.
// Forms the normal products, scales by the radius, rounds and saturates.
// Depends on uvs_pkg.
`default_nettype none

module uvs_vertex_unit
   import uvs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] radius,
   input  wire vtx_op_type  op,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   localparam int PRD_W = 2 * CS_W;
   localparam int POS_W = NV_W + 17;

   function automatic logic [15:0] to_norm(logic signed [NV_W-1:0] v);
      logic signed [NV_W:0] r;
      r = ((NV_W+1)'(v) + (NV_W+1)'(16384)) >>> 15;
      if (r > (NV_W+1)'(32767)) begin
         return 16'h7FFF;
      end else if (r < -(NV_W+1)'(32768)) begin
         return 16'h8000;
      end
      return r[15:0];
   endfunction

   function automatic logic [23:0] to_pos(logic signed [POS_W-1:0] p);
      logic signed [POS_W:0] r;
      r = ((POS_W+1)'(p) + (POS_W+1)'(4194304)) >>> 23;
      if (r > (POS_W+1)'(8388607)) begin
         return 24'h7FFFFF;
      end else if (r < -(POS_W+1)'(8388608)) begin
         return 24'h800000;
      end
      return r[23:0];
   endfunction

   // stage one: normal products
   vtx_op_type              s1_op_ff;
   logic signed [PRD_W-1:0] nx_prod_ff, nz_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff.valid <= 1'b0;
      end else begin
         s1_op_ff <= op;
      end
      nx_prod_ff <= PRD_W'(op.clon) * PRD_W'(op.clat);
      nz_prod_ff <= PRD_W'(op.clat) * PRD_W'(op.slon);
   end

   // stage two: round to Q3.30 and scale by the radius
   vtx_op_type              s2_op_ff;
   logic signed [NV_W-1:0]  nx_v, nz_v, ny_v;
   logic signed [16:0]      rad_s;
   logic signed [NV_W-1:0]  nrm_ff [3];
   logic signed [POS_W-1:0] pos_ff [3];

   always_comb begin
      nx_v = NV_W'((nx_prod_ff + PRD_W'(64'sd536870912)) >>> 30);
      nz_v = NV_W'((nz_prod_ff + PRD_W'(64'sd536870912)) >>> 30);
      ny_v = s1_op_ff.slat;
      rad_s = signed'({1'b0, radius});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_op_ff.valid <= 1'b0;
      end else begin
         s2_op_ff <= s1_op_ff;
      end
      nrm_ff[0] <= nx_v;
      nrm_ff[1] <= ny_v;
      nrm_ff[2] <= nz_v;
      pos_ff[0] <= POS_W'(nx_v) * POS_W'(rad_s);
      pos_ff[1] <= POS_W'(ny_v) * POS_W'(rad_s);
      pos_ff[2] <= POS_W'(nz_v) * POS_W'(rad_s);
   end

   // stage three: saturate and drive the result; a bad item gives zeros
   rsp_type rsp_in, rsp_ff;
   logic    rsp_valid_ff;

   always_comb begin
      rsp_in = '0;
      if (s2_op_ff.bad) begin
         rsp_in.bad_index = 1'b1;
      end else begin
         rsp_in.vertex_slot = s2_op_ff.slot;
         rsp_in.pos_x  = to_pos(pos_ff[0]);
         rsp_in.pos_y  = to_pos(pos_ff[1]);
         rsp_in.pos_z  = to_pos(pos_ff[2]);
         rsp_in.norm_x = to_norm(nrm_ff[0]);
         rsp_in.norm_y = to_norm(nrm_ff[1]);
         rsp_in.norm_z = to_norm(nrm_ff[2]);
         rsp_in.tex_u  = s2_op_ff.tex_u;
         rsp_in.tex_v  = s2_op_ff.tex_v;
         rsp_in.last   = s2_op_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_op_ff.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[rtl/uv_sphere_vertex_generator_core.sv]
// UV sphere vertex generator: one grid point in, four vertex items out (one flagged item if bad).
// busy is high after an accepted start while the three divisions are issued; a new item is
// taken only while busy is low. Each vertex passes the 41-cell divider chain, the CORDIC chain,
// the quadrant fold, the emit bank and the vertex unit; an item's vertices follow in slot order.
// Synchronous reset clears control state and loads radius 1.0 and level 8.
// The receiver cannot stall: results are strobed on rsp_valid for one cycle each.
`default_nettype none

module uv_sphere_vertex_generator_core
   import uvs_pkg::*;
#(
   parameter int MAX_LEVEL    = 255,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // configuration registers
   logic [15:0]      radius_ff;
   logic [LVL_W-1:0] level_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256;
         level_ff  <= 8'd8;
      end else if (csr_valid) begin
         case (csr_index)
            REG_RADIUS: begin
               radius_ff <= csr_wdata;
            end
            REG_LEVEL: begin
               level_ff <= csr_wdata[LVL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // accept an item and check its indices
   logic        accept;
   logic        bad_in;
   logic        act_ff;
   logic [1:0]  op_cnt_ff;
   logic [7:0]  band_ff;
   logic [8:0]  mer_ff;
   logic        bad_ff;

   assign accept = start && !busy;
   assign busy   = act_ff;

   always_comb begin
      bad_in = (level_ff == '0)
            || ({1'b0, level_ff} > 9'(MAX_LEVEL))
            || (req_data.band_index >= level_ff)
            || ({1'b0, req_data.meridian_index} > {1'b0, level_ff, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff    <= 1'b0;
         op_cnt_ff <= OP_LAT_LO;
      end else if (accept) begin
         act_ff    <= 1'b1;
         op_cnt_ff <= OP_LAT_LO;
      end else if (act_ff) begin
         op_cnt_ff <= op_cnt_ff + 2'd1;
         if (op_cnt_ff == OP_LON) begin
            act_ff <= 1'b0;
         end
      end
      if (accept) begin
         band_ff <= req_data.band_index;
         mer_ff  <= req_data.meridian_index;
         bad_ff  <= bad_in;
      end
   end

   // issue one division per cycle: both latitude edges, then the longitude
   logic [IDX_W-1:0] num_a, num_b;
   logic [REM_W-1:0] divisor;
   op_tag_type       div_tag [DIV_W+1];
   div_lane_type     div_a   [DIV_W+1];
   div_lane_type     div_b   [DIV_W+1];

   assign divisor = {level_ff, 1'b0};

   always_comb begin
      case (op_cnt_ff)
         OP_LAT_LO: begin
            num_a = IDX_W'(band_ff);
            num_b = IDX_W'(band_ff);
         end
         OP_LAT_HI: begin
            num_a = IDX_W'(band_ff) + 10'd1;
            num_b = IDX_W'(band_ff) + 10'd1;
         end
         OP_LON: begin
            num_a = {mer_ff, 1'b0};
            num_b = IDX_W'(mer_ff);
         end
         default: begin
            num_a = '0;
            num_b = '0;
         end
      endcase
      div_tag[0].valid = act_ff;
      div_tag[0].bad   = bad_ff;
      div_tag[0].op    = op_cnt_ff;
      div_tag[0].aux   = '0;
      div_a[0].rem  = '0;
      div_a[0].word = {num_a, 23'd0, level_ff};
      div_b[0].rem  = '0;
      div_b[0].word = {15'd0, num_b, 8'd0, level_ff};
   end

   for (genvar i = 0; i < DIV_W; i++) begin : g_div
      uvs_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .divisor (divisor),
         .up_tag  (div_tag[i]),
         .up_a    (div_a[i]),
         .up_b    (div_b[i]),
         .dn_tag  (div_tag[i+1]),
         .dn_a    (div_a[i+1]),
         .dn_b    (div_b[i+1])
      );
   end

   // CORDIC chain on the quotient phase; the tex share rides along
   op_tag_type cord_tag [CORDIC_STEPS+1];
   rot_type    cord_rot [CORDIC_STEPS+1];

   always_comb begin
      cord_tag[0]     = div_tag[DIV_W];
      cord_tag[0].aux = div_b[DIV_W].word[AUX_W-1:0];
      cord_rot[0].x    = CORDIC_GAIN;
      cord_rot[0].y    = '0;
      cord_rot[0].z    = signed'({2'b00, div_a[DIV_W].word[29:0]});
      cord_rot[0].quad = div_a[DIV_W].word[31:30];
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      uvs_cordic_cell #(
         .STEP (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .up_tag (cord_tag[i]),
         .up_rot (cord_rot[i]),
         .dn_tag (cord_tag[i+1]),
         .dn_rot (cord_rot[i+1])
      );
   end

   // fold the quadrant back in
   op_tag_type             qd_tag_ff;
   logic signed [CS_W-1:0] sin_ff, cos_ff, sin_in, cos_in;
   rot_type                rot_end;

   always_comb begin
      rot_end = cord_rot[CORDIC_STEPS];
      case (rot_end.quad)
         2'd0: begin
            cos_in = CS_W'(rot_end.x);
            sin_in = CS_W'(rot_end.y);
         end
         2'd1: begin
            cos_in = CS_W'(-rot_end.y);
            sin_in = CS_W'(rot_end.x);
         end
         2'd2: begin
            cos_in = CS_W'(-rot_end.x);
            sin_in = CS_W'(-rot_end.y);
         end
         default: begin
            cos_in = CS_W'(rot_end.y);
            sin_in = CS_W'(-rot_end.x);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qd_tag_ff.valid <= 1'b0;
      end else begin
         qd_tag_ff <= cord_tag[CORDIC_STEPS];
      end
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   // collect the three results of an item and load the emit bank
   logic signed [CS_W-1:0] slat0_ff, clat0_ff, slat1_ff, clat1_ff;
   logic [AUX_W-1:0]       share0_ff, share1_ff;
   logic signed [CS_W-1:0] bk_slat0_ff, bk_clat0_ff, bk_slat1_ff, bk_clat1_ff;
   logic signed [CS_W-1:0] bk_slon_ff, bk_clon_ff;
   logic [AUX_W-1:0]       bk_share0_ff, bk_share1_ff, bk_u_ff;
   logic                   bk_bad_ff;
   logic                   emit_act_ff;
   logic [1:0]             slot_ff;
   logic                   bank_load;

   assign bank_load = qd_tag_ff.valid && (qd_tag_ff.op == OP_LON);

   always_ff @(posedge clock) begin
      if (qd_tag_ff.valid) begin
         case (qd_tag_ff.op)
            OP_LAT_LO: begin
               slat0_ff  <= sin_ff;
               clat0_ff  <= cos_ff;
               share0_ff <= qd_tag_ff.aux;
            end
            OP_LAT_HI: begin
               slat1_ff  <= sin_ff;
               clat1_ff  <= cos_ff;
               share1_ff <= qd_tag_ff.aux;
            end
            default: begin
            end
         endcase
      end
      if (bank_load) begin
         bk_slat0_ff  <= slat0_ff;
         bk_clat0_ff  <= clat0_ff;
         bk_slat1_ff  <= slat1_ff;
         bk_clat1_ff  <= clat1_ff;
         bk_share0_ff <= share0_ff;
         bk_share1_ff <= share1_ff;
         bk_slon_ff   <= sin_ff;
         bk_clon_ff   <= cos_ff;
         bk_u_ff      <= qd_tag_ff.aux;
         bk_bad_ff    <= qd_tag_ff.bad;
      end
   end

   // step through the four vertex slots
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_act_ff <= 1'b0;
         slot_ff     <= 2'd0;
      end else if (bank_load) begin
         emit_act_ff <= 1'b1;
         slot_ff     <= 2'd0;
      end else if (emit_act_ff) begin
         slot_ff <= slot_ff + 2'd1;
         if (slot_ff == SLOT_LAST) begin
            emit_act_ff <= 1'b0;
         end
      end
   end

   // select the edge of this slot; the south mirrors sin(lat)
   vtx_op_type             vop;
   logic signed [CS_W-1:0] slat_sel;
   logic [AUX_W-1:0]       share_sel;

   always_comb begin
      slat_sel  = slot_ff[0] ? bk_slat1_ff : bk_slat0_ff;
      share_sel = slot_ff[0] ? bk_share1_ff : bk_share0_ff;
      vop.valid = emit_act_ff && ((slot_ff == 2'd0) || !bk_bad_ff);
      vop.bad   = bk_bad_ff;
      vop.last  = (slot_ff == SLOT_LAST);
      vop.slot  = slot_ff;
      vop.clat  = slot_ff[0] ? bk_clat1_ff : bk_clat0_ff;
      vop.slat  = slot_ff[1] ? -NV_W'(slat_sel) : NV_W'(slat_sel);
      vop.clon  = bk_clon_ff;
      vop.slon  = bk_slon_ff;
      vop.tex_u = bk_u_ff;
      vop.tex_v = slot_ff[1] ? (17'd32768 - share_sel) : (17'd32768 + share_sel);
   end

   uvs_vertex_unit u_vertex (
      .clock     (clock),
      .reset     (reset),
      .radius    (radius_ff),
      .op        (vop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/uvs_checker.sv]
// uvs_checker: port-level checks on the vertex generator, bound to its top level.
// Watches the start/busy handshake and the ordering of the vertex items.
// Depends on uvs_pkg.
`default_nettype none

module uvs_checker
   import uvs_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // an accepted item raises busy, which falls again once its three divisions are issued
   a_busy_span: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy ##1 busy ##1 busy ##1 !busy)
      else $error("busy span after accept is wrong");

   // last marks slot three only
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.bad_index |-> (rsp_data.last == (rsp_data.vertex_slot == SLOT_LAST)))
      else $error("last flag does not match slot");

   // a bad item gives a single zeroed result
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_index |-> rsp_data.vertex_slot == 2'd0 && !rsp_data.last
         && rsp_data.pos_x == '0 && rsp_data.norm_y == '0 && rsp_data.tex_v == '0)
      else $error("bad item result not zeroed");

   // slots follow one another on consecutive cycles
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.vertex_slot != 2'd0 |->
         $past(rsp_valid) && ($past(rsp_data.vertex_slot) == rsp_data.vertex_slot - 2'd1))
      else $error("vertex slot out of order");

   // a bad result is never followed by further slots of the same item
   a_bad_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_index |=> !rsp_valid || rsp_data.vertex_slot == 2'd0)
      else $error("slots follow a bad result");

endmodule

bind uv_sphere_vertex_generator_core uvs_checker u_uvs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[sim/uv_sphere_vertex_generator_core_tb.sv]
// Self-checking testbench for the UV sphere vertex generator core.
// Drives grid points and register writes, predicts vertices in fixed point, checks each one.
// Depends on uvs_pkg and uv_sphere_vertex_generator_core.
`default_nettype none

module uv_sphere_vertex_generator_core_tb;
   import uvs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_LATENCY = 49 + 16 + 16;
   localparam int CYCLE_LIMIT  = 400000;

   // register indexes with no register behind them
   localparam logic [1:0] REG_SPARE_A = 2'd2;
   localparam logic [1:0] REG_SPARE_B = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   uv_sphere_vertex_generator_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow registers of the predictor
   logic [15:0] radius_q = 16'd256;
   logic [7:0]  level_q  = 8'd8;
   rsp_type     vertex_queue[$];
   int          error_count = 0;
   int          cycle_count = 0;

   localparam longint ATAN_Q[0:23] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
   };

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // rotation CORDIC on a Q0.32 turn phase, sine and cosine in Q2.30
   task automatic rotate_phase(input logic [31:0] phase, output longint s, output longint c);
      longint x, y, z, dx, dy;
      x = 652032874; y = 0; z = phase[29:0];
      for (int i = 0; i < 16; i++) begin
         dx = floor_shift(y, i); dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_Q[i];
         end else begin
            x += dx; y -= dy; z += ATAN_Q[i];
         end
      end
      case (phase[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   function automatic logic [15:0] as_normal(longint v);
      return 16'(clip(floor_shift(v + (64'sd1 << 14), 15), -32768, 32767));
   endfunction

   function automatic logic [23:0] as_position(longint v);
      return 24'(clip(floor_shift(v * longint'(radius_q) + (64'sd1 << 22), 23),
                      -8388608, 8388607));
   endfunction

   // queue the vertices one grid point produces
   task automatic predict_vertices(input req_type pt);
      longint lvl, k, slon, clon, slat, clat, nx, nz, share;
      rsp_type v;
      lvl = level_q;
      if (lvl == 0 || pt.band_index >= lvl || pt.meridian_index > 2 * lvl) begin
         v = '0; v.bad_index = 1'b1;
         vertex_queue = {vertex_queue, v};
         return;
      end
      rotate_phase(32'(((longint'(pt.meridian_index) << 32) + lvl) / (2 * lvl)), slon, clon);
      for (int slot = 0; slot < 4; slot++) begin
         k = pt.band_index + (slot & 1);
         share = (k * 65536 + lvl) / (2 * lvl);
         rotate_phase(32'(((k << 31) + lvl) / (2 * lvl)), slat, clat);
         if (slot >= 2) slat = -slat;
         nx = floor_shift(clon * clat + (64'sd1 << 29), 30);
         nz = floor_shift(clat * slon + (64'sd1 << 29), 30);
         v = '0;
         v.vertex_slot = 2'(slot);
         v.pos_x = as_position(nx); v.pos_y = as_position(slat); v.pos_z = as_position(nz);
         v.norm_x = as_normal(nx); v.norm_y = as_normal(slat); v.norm_z = as_normal(nz);
         v.tex_u = 17'((longint'(pt.meridian_index) * 65536 + lvl) / (2 * lvl));
         v.tex_v = 17'(slot < 2 ? 32768 + share : 32768 - share);
         v.last = (slot == 3);
         vertex_queue = {vertex_queue, v};
      end
   endtask

   // compare each strobed vertex with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (vertex_queue.size() == 0) begin
            $error("unexpected vertex item: %p", rsp_data);
            error_count++;
         end else begin
            want = vertex_queue.pop_front();
            if (rsp_data.vertex_slot !== want.vertex_slot) begin
               $error("vertex_slot exp %0d got %0d", want.vertex_slot, rsp_data.vertex_slot);
               error_count++;
            end
            if (rsp_data.pos_x !== want.pos_x) begin
               $error("pos_x exp %0d got %0d", want.pos_x, rsp_data.pos_x); error_count++;
            end
            if (rsp_data.pos_y !== want.pos_y) begin
               $error("pos_y exp %0d got %0d", want.pos_y, rsp_data.pos_y); error_count++;
            end
            if (rsp_data.pos_z !== want.pos_z) begin
               $error("pos_z exp %0d got %0d", want.pos_z, rsp_data.pos_z); error_count++;
            end
            if (rsp_data.norm_x !== want.norm_x) begin
               $error("norm_x exp %0d got %0d", want.norm_x, rsp_data.norm_x); error_count++;
            end
            if (rsp_data.norm_y !== want.norm_y) begin
               $error("norm_y exp %0d got %0d", want.norm_y, rsp_data.norm_y); error_count++;
            end
            if (rsp_data.norm_z !== want.norm_z) begin
               $error("norm_z exp %0d got %0d", want.norm_z, rsp_data.norm_z); error_count++;
            end
            if (rsp_data.tex_u !== want.tex_u) begin
               $error("tex_u exp %0d got %0d", want.tex_u, rsp_data.tex_u); error_count++;
            end
            if (rsp_data.tex_v !== want.tex_v) begin
               $error("tex_v exp %0d got %0d", want.tex_v, rsp_data.tex_v); error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last exp %0d got %0d", want.last, rsp_data.last); error_count++;
            end
            if (rsp_data.bad_index !== want.bad_index) begin
               $error("bad_index exp %0d got %0d", want.bad_index, rsp_data.bad_index);
               error_count++;
            end
         end
      end
   end

   // end the run on a hung block
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   int burst_left = 0;

   // send one grid point, with bursts and gaps before it; start stays high inside a burst
   task automatic send_point(input req_type pt, input bit typed_bad = 1'b0);
      rsp_type flagged;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            start    <= 1'b0;
            req_data <= req_type'(17'($urandom));
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= pt;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (typed_bad) begin
         flagged = '0;
         flagged.bad_index = 1'b1;
         vertex_queue = {vertex_queue, flagged};
      end else begin
         predict_vertices(pt);
      end
   endtask

   // drop start at the end of a stretch of items
   task automatic stop_sending;
      start    <= 1'b0;
      req_data <= req_type'(17'($urandom));
      burst_left = 0;
   endtask

   // let the pipeline drain before touching registers
   task automatic drain;
      while (vertex_queue.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_RADIUS) radius_q = value;
      else if (idx == REG_LEVEL) level_q = value[7:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type random_point(input int lvl);
      req_type p;
      int pick;
      pick = $urandom_range(0, 15);
      if (lvl == 0) lvl = 1;
      p.band_index     = 8'($urandom_range(0, lvl - 1));
      p.meridian_index = 9'($urandom_range(0, 2 * lvl));
      if (pick == 0) p.band_index = 8'($urandom);
      else if (pick == 1) p.meridian_index = 9'($urandom);
      else if (pick == 2) p.meridian_index = 9'(2 * lvl);
      return p;
   endfunction

   // directed rows: band, meridian, and 1 where a lone flagged item is expected
   typedef struct {
      int band;
      int meridian;
      bit bad;
   } point_row_type;

   localparam int DIRECTED_N = 12;
   point_row_type directed_rows[DIRECTED_N] = '{
      '{0, 0, 0}, '{7, 0, 0}, '{0, 16, 0}, '{3, 8, 0}, '{7, 15, 0}, '{8, 0, 1},
      '{0, 17, 1}, '{255, 0, 1}, '{0, 511, 1}, '{255, 511, 1}, '{4, 4, 0}, '{1, 12, 0}
   };

   // radius and level pairs walked by the random phases
   localparam int PHASES = 6;
   int phase_radius[PHASES] = '{65535, 0, 256, 1000, 40000, 128};
   int phase_level[PHASES]  = '{255, 1, 8, 3, 17, 0};

   initial begin
      req_type pt;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values; out-of-range rows give a lone flagged item
      foreach (directed_rows[i]) begin
         pt.band_index     = 8'(directed_rows[i].band);
         pt.meridian_index = 9'(directed_rows[i].meridian);
         send_point(pt, directed_rows[i].bad);
      end
      stop_sending();
      drain();
      // unused register index is dropped
      write_register(REG_SPARE_B, 16'hFFFF);
      write_register(REG_SPARE_A, 16'h0000);

      for (int ph = 0; ph < PHASES; ph++) begin
         write_register(REG_RADIUS, 16'(phase_radius[ph]));
         write_register(REG_LEVEL, 16'($urandom_range(0, 255) << 8) | 16'(phase_level[ph]));
         // poles and overflow at the extremes of this setting
         if (level_q != 0) begin
            pt.band_index = 8'(level_q - 8'd1); pt.meridian_index = 9'(2 * level_q);
            send_point(pt);
         end
         repeat (53) send_point(random_point(level_q));
         stop_sending();
         drain();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
rtl/uvs_pkg.sv
rtl/uvs_div_cell.sv
rtl/uvs_cordic_cell.sv
rtl/uvs_vertex_unit.sv
rtl/uv_sphere_vertex_generator_core.sv
rtl/uvs_checker.sv
sim/uv_sphere_vertex_generator_core_tb.sv
